### hdl/mst_pkg.sv
// Shared types and codes for the minimum-tracking stack.
package mst_pkg;

	localparam int DATA_W = 32;
	localparam int FILL_W = 7;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		word_t value;
		word_t minimum;
	} entry_t;

	typedef struct packed {
		logic   wr_en;
		logic   rd_en;
		entry_t wr_data;
	} mem_cmd_t;

endpackage

### hdl/mst_if.sv
// Request and response channel interfaces for the minimum-tracking stack.
interface mst_req_if;
	logic          valid;
	logic          ready;
	logic          func;
	mst_pkg::word_t value_in;

	modport source(output valid, output func, output value_in, input ready);
	modport sink(input valid, input func, input value_in, output ready);
endinterface

interface mst_rsp_if;
	logic                         valid;
	logic                         ready;
	mst_pkg::word_t               value_out;
	mst_pkg::word_t               min_out;
	logic                         is_empty;
	logic [mst_pkg::FILL_W-1:0]   fill_count;
	logic [1:0]                   status;

	modport source(output valid, output value_out, output min_out, output is_empty,
		output fill_count, output status, input ready);
	modport sink(input valid, input value_out, input min_out, input is_empty,
		input fill_count, input status, output ready);
endinterface

### hdl/mst_mem.sv
// Entry memory: value and running minimum per level, one write and one registered read port.
module mst_mem #(
	parameter  int DEPTH  = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  mst_pkg::mem_cmd_t cmd,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ADDR_W-1:0] rd_addr,
	output mst_pkg::entry_t   rd_data
);

	mst_pkg::entry_t mem_q [DEPTH];
	mst_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/mst_ctrl.sv
// Stack control: fill count, cached top entry, memory sequencing and result register.
module mst_ctrl #(
	parameter  int CAPACITY = 64,
	localparam int ADDR_W   = $clog2(CAPACITY)
) (
	input  logic              clk,
	input  logic              arst_n,
	mst_req_if.sink           req,
	mst_rsp_if.source         rsp,
	output mst_pkg::mem_cmd_t mem_cmd,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [ADDR_W-1:0] rd_addr,
	input  mst_pkg::entry_t   rd_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic                       state_q;
	logic [CNT_W-1:0]           count_q;
	mst_pkg::word_t             top_val_q;
	mst_pkg::word_t             top_min_q;
	logic                       out_valid_q;
	mst_pkg::word_t             out_value_q;
	mst_pkg::word_t             out_min_q;
	logic                       out_empty_q;
	logic [mst_pkg::FILL_W-1:0] out_fill_q;
	logic [1:0]                 out_status_q;

	logic             slot_free;
	logic             acc;
	logic             is_push;
	logic             full;
	logic             empty;
	logic             set_valid;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_dec;
	mst_pkg::word_t   push_min;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;
	assign is_push   = (req.func == mst_pkg::FUNC_PUSH);
	assign full      = (count_q == CAP_CNT);
	assign empty     = (count_q == '0);
	assign cnt_inc   = count_q + 1'b1;
	assign cnt_dec   = count_q - 1'b1;
	assign push_min  = (!empty && (top_min_q < req.value_in)) ? top_min_q : req.value_in;

	// Push and ignored words finish at once; a successful pop finishes in ST_POP.
	assign set_valid = ((state_q == ST_IDLE) && acc && (is_push || empty)) ||
		(state_q == ST_POP);

	// Pop refills the top cache from the entry just below the old top.
	assign wr_addr           = count_q[ADDR_W-1:0];
	assign rd_addr           = ADDR_W'(count_q - CNT_W'(2));
	assign mem_cmd.wr_en     = acc && is_push && !full;
	assign mem_cmd.rd_en     = acc && !is_push && (count_q > CNT_W'(1));
	assign mem_cmd.wr_data   = '{value: req.value_in, minimum: push_min};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (set_valid) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (is_push) begin
							if (!full) begin
								count_q <= cnt_inc;
							end
						end else if (!empty) begin
							count_q <= cnt_dec;
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (is_push) begin
						out_value_q <= '0;
						out_empty_q <= 1'b0;
						if (full) begin
							out_min_q    <= top_min_q;
							out_fill_q   <= mst_pkg::FILL_W'(count_q);
							out_status_q <= mst_pkg::STATUS_PUSH_FULL;
						end else begin
							top_val_q    <= req.value_in;
							top_min_q    <= push_min;
							out_min_q    <= push_min;
							out_fill_q   <= mst_pkg::FILL_W'(cnt_inc);
							out_status_q <= mst_pkg::STATUS_OK;
						end
					end else if (empty) begin
						out_value_q  <= '0;
						out_min_q    <= '0;
						out_empty_q  <= 1'b1;
						out_fill_q   <= '0;
						out_status_q <= mst_pkg::STATUS_POP_EMPTY;
					end else begin
						out_value_q <= top_val_q;
					end
				end
			end
			ST_POP: begin
				// count_q already holds the count after the pop
				top_val_q    <= rd_data.value;
				top_min_q    <= rd_data.minimum;
				out_min_q    <= (count_q == '0) ? '0 : rd_data.minimum;
				out_empty_q  <= (count_q == '0);
				out_fill_q   <= mst_pkg::FILL_W'(count_q);
				out_status_q <= mst_pkg::STATUS_OK;
			end
			default: begin
				out_status_q <= mst_pkg::STATUS_OK;
			end
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.value_out  = out_value_q;
	assign rsp.min_out    = out_min_q;
	assign rsp.is_empty   = out_empty_q;
	assign rsp.fill_count = out_fill_q;
	assign rsp.status     = out_status_q;

endmodule

### hdl/min_tracking_stack_top.sv
// Top level of the minimum-tracking stack.
//
//   channel  dir  word                               handshake
//   req      in   func, value_in                     valid/ready
//   rsp      out  value_out, min_out, is_empty,      valid/ready
//                 fill_count, status
//
// A push (or any ignored item) is answered from the cached top; a successful pop
// also passes through ST_POP, as the entry memory's registered read refills the cached top.
// Reset clears the count and control only; the memory needs no clearing pass.
// The result sits in an output register; while it waits, req.ready stays low
// unless rsp.ready drains it in the same cycle.
module min_tracking_stack_top #(
	parameter int CAPACITY = 64
) (
	input logic       clk,
	input logic       arst_n,
	mst_req_if.sink   req,
	mst_rsp_if.source rsp
);

	localparam int ADDR_W = $clog2(CAPACITY);

	mst_pkg::mem_cmd_t mem_cmd;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	mst_pkg::entry_t   rd_data;

	mst_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_cmd (mem_cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mst_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk     (clk),
		.cmd     (mem_cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

### hdl/mst_checker.sv
// Port-level assertions for the minimum-tracking stack, bound to the top level.
module mst_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input mst_pkg::word_t             value_out,
	input mst_pkg::word_t             min_out,
	input logic                       is_empty,
	input logic [1:0]                 status
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// Hold a stalled result word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A result appears only after an accepted request.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(in_acc) || $past(in_acc, 2)))
		else $error("result without a request");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mst_pkg::STATUS_POP_EMPTY) |->
			is_empty && (value_out == '0) && (min_out == '0))
		else $error("pop on empty result wrong");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mst_pkg::STATUS_PUSH_FULL) |->
			!is_empty && (value_out == '0))
		else $error("push on full result wrong");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (min_out == '0))
		else $error("empty stack reports a minimum");

endmodule

bind min_tracking_stack_top mst_checker u_mst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.value_out (rsp.value_out),
	.min_out   (rsp.min_out),
	.is_empty  (rsp.is_empty),
	.status    (rsp.status)
);

### dv/tb_top.sv
// Self-checking testbench for the minimum-tracking stack top level.
`timescale 1ns / 100ps

module tb_top;
	import mst_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_PHASES = 24;
	localparam int PHASE_WORDS = 50;

	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		word_t             value;
		word_t             minimum;
		logic              empty;
		logic [FILL_W-1:0] fill;
		logic [1:0]        status;
	} stack_result_t;

	typedef struct packed {
		logic          func;
		word_t         value;
		logic [7:0]    reps;
		logic          pinned;
		stack_result_t want;
	} op_row_t;

	localparam int DIR_ROWS = 20;
	localparam op_row_t DIRECTED [DIR_ROWS] = '{
		'{FUNC_POP,  32'sd0,      8'd1,  1'b1, '{32'sd0, 32'sd0, 1'b1, 7'd0, STATUS_POP_EMPTY}},
		'{FUNC_PUSH, WORD_MAX,    8'd1,  1'b1, '{32'sd0, WORD_MAX, 1'b0, 7'd1, STATUS_OK}},
		'{FUNC_PUSH, WORD_MIN,    8'd1,  1'b1, '{32'sd0, WORD_MIN, 1'b0, 7'd2, STATUS_OK}},
		'{FUNC_PUSH, 32'sd5,      8'd1,  1'b0, '0},
		'{FUNC_PUSH, WORD_MIN,    8'd1,  1'b0, '0},
		'{FUNC_PUSH, -32'sd1,     8'd1,  1'b0, '0},
		'{FUNC_POP,  32'sd0,      8'd4,  1'b0, '0},
		'{FUNC_POP,  32'sd0,      8'd1,  1'b1, '{WORD_MAX, 32'sd0, 1'b1, 7'd0, STATUS_OK}},
		'{FUNC_POP,  -32'sd1,     8'd1,  1'b1, '{32'sd0, 32'sd0, 1'b1, 7'd0, STATUS_POP_EMPTY}},
		'{FUNC_PUSH, 32'sd0,      8'd1,  1'b0, '0},
		'{FUNC_PUSH, 32'sd0,      8'd1,  1'b0, '0},
		'{FUNC_PUSH, 32'sd1,      8'd1,  1'b0, '0},
		'{FUNC_POP,  WORD_MIN,    8'd3,  1'b0, '0},
		'{FUNC_PUSH, -32'sd7,     8'd64, 1'b0, '0},
		'{FUNC_PUSH, WORD_MIN,    8'd1,  1'b1, '{32'sd0, -32'sd7, 1'b0, 7'd64, STATUS_PUSH_FULL}},
		'{FUNC_POP,  32'sd0,      8'd1,  1'b0, '0},
		'{FUNC_PUSH, WORD_MAX,    8'd1,  1'b0, '0},
		'{FUNC_PUSH, -32'sd8,     8'd1,  1'b1, '{32'sd0, -32'sd7, 1'b0, 7'd64, STATUS_PUSH_FULL}},
		'{FUNC_POP,  32'sd0,      8'd64, 1'b0, '0},
		'{FUNC_POP,  WORD_MAX,    8'd1,  1'b1, '{32'sd0, 32'sd0, 1'b1, 7'd0, STATUS_POP_EMPTY}}
	};

	logic clk;
	logic arst_n;

	mst_req_if req_ch();
	mst_rsp_if rsp_ch();

	min_tracking_stack_top #(
		.CAPACITY(DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	word_t         stack_vals [DEPTH];
	word_t         stack_mins [DEPTH];
	int            stack_depth;
	stack_result_t pending_results [$];
	int            mismatches;
	int            cycle_count;

	// pinned expectation that goes with the word currently offered
	logic          pin_on;
	stack_result_t pin_exp;

	bit calm;
	bit long_hold;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic stack_result_t track_stack_op(logic f, word_t v);
		stack_result_t r;
		r = '0;
		r.status = STATUS_OK;
		if (f == FUNC_PUSH) begin
			if (stack_depth >= DEPTH) begin
				r.status = STATUS_PUSH_FULL;
			end else begin
				stack_vals[stack_depth] = v;
				stack_mins[stack_depth] = v;
				if (stack_depth > 0) begin
					if (stack_mins[stack_depth-1] < v)
						stack_mins[stack_depth] = stack_mins[stack_depth-1];
				end
				stack_depth++;
			end
		end else if (stack_depth == 0) begin
			r.status = STATUS_POP_EMPTY;
		end else begin
			stack_depth--;
			r.value = stack_vals[stack_depth];
		end
		if (stack_depth > 0)
			r.minimum = stack_mins[stack_depth-1];
		r.empty = (stack_depth == 0);
		r.fill  = FILL_W'(stack_depth);
		return r;
	endfunction

	task automatic offer_word(input logic f, input word_t v, input logic pinned,
		input stack_result_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.func     <= f;
		req_ch.value_in <= v;
		pin_on  = pinned;
		pin_exp = want;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	always @(posedge clk) begin : scoreboard
		stack_result_t got;
		stack_result_t want;
		stack_result_t calc;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.value_out, rsp_ch.min_out, rsp_ch.is_empty,
				rsp_ch.fill_count, rsp_ch.status};
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word value=%0d min=%0d empty=%0b fill=%0d status=%0d",
					$time, got.value, got.minimum, got.empty, got.fill, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected value=%0d min=%0d empty=%0b fill=%0d status=%0d",
						$time, want.value, want.minimum, want.empty, want.fill, want.status);
					$display("%0t:   actual value=%0d min=%0d empty=%0b fill=%0d status=%0d",
						$time, got.value, got.minimum, got.empty, got.fill, got.status);
				end
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			calc = track_stack_op(req_ch.func, req_ch.value_in);
			pending_results.push_back(pin_on ? pin_exp : calc);
		end
	end

	// result side: random stall before each word unless calm, one long hold-off on request
	initial begin : rsp_drain
		int gap;
		forever begin
			if (long_hold) begin
				gap = LONG_HOLD;
				long_hold = 1'b0;
			end else if (calm) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 7);
			end
			if (gap > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL min_tracking_stack_top");
		$finish;
	end

	initial begin : stimulus
		int    push_pct;
		logic  f;
		word_t v;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.func     = FUNC_PUSH;
		req_ch.value_in = '0;
		rsp_ch.ready    = 1'b0;
		pin_on          = 1'b0;
		pin_exp         = '0;
		calm            = 1'b0;
		long_hold       = 1'b0;
		stack_depth     = 0;
		mismatches      = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[r]) begin
			repeat (DIRECTED[r].reps)
				offer_word(DIRECTED[r].func, DIRECTED[r].value, DIRECTED[r].pinned,
					DIRECTED[r].want);
		end
		// drop the last word before waiting for the block to drain
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: push_pct = 50;
				1: push_pct = 95;
				2: push_pct = 5;
				3: push_pct = 70;
				default: push_pct = 30;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			// hold the result side while words keep coming, so the input stalls
			if (ph == 4) begin
				calm = 1'b0;
				long_hold = 1'b1;
			end
			for (int i = 0; i < PHASE_WORDS; i++) begin
				f = ($urandom_range(1, 100) <= push_pct) ? FUNC_PUSH : FUNC_POP;
				case ($urandom_range(0, 7))
					0: v = WORD_MAX;
					1: v = WORD_MIN;
					2, 3: v = word_t'($urandom_range(0, 16)) - 8;
					default: v = $urandom;
				endcase
				offer_word(f, v, 1'b0, '0);
			end
			// every fourth phase, pause the input until the block has drained
			if (ph % 4 == 3) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
		end
		calm = 1'b0;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS min_tracking_stack_top");
		else
			$display("FAIL min_tracking_stack_top");
		$finish;
	end

endmodule
